// File: sv/pmct_pkg.sv
// Shared constants for the PS/2 mouse cursor tracker.
// No dependencies; used by the channel interfaces and the top level.
package pmct_pkg;

    localparam int MAX_SCREEN_DEF = 4096;

    localparam int BYTE_W    = 8;
    localparam int COORD_W   = 12;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;

    localparam logic [CFG_W-1:0] SCREEN_WIDTH_RST  = 13'd640;
    localparam logic [CFG_W-1:0] SCREEN_HEIGHT_RST = 13'd480;

    // Header byte bit positions
    localparam int SYNC_BIT  = 3;
    localparam int LEFT_BIT  = 0;
    localparam int RIGHT_BIT = 1;

    localparam int START_POS = 100;

    typedef struct packed {
        logic [COORD_W-1:0] cursor_x;
        logic [COORD_W-1:0] cursor_y;
        logic               left_down;
        logic               right_down;
    } t_result;

endpackage

// File: sv/pmct_in_if.sv
// Input byte channel: valid/ready handshake carrying one received PS/2 byte.
// Depends on pmct_pkg.
interface pmct_in_if;
    logic                       valid;
    logic                       ready;
    logic [pmct_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// File: sv/pmct_out_if.sv
// Result channel: valid/ready handshake carrying cursor position and buttons.
// Depends on pmct_pkg.
interface pmct_out_if;
    logic                         valid;
    logic                         ready;
    logic [pmct_pkg::COORD_W-1:0] cursor_x;
    logic [pmct_pkg::COORD_W-1:0] cursor_y;
    logic                         left_down;
    logic                         right_down;

    modport source (output valid, output cursor_x, output cursor_y,
                    output left_down, output right_down, input ready);
    modport sink   (input valid, input cursor_x, input cursor_y,
                    input left_down, input right_down, output ready);
endinterface

// File: sv/ps2_mouse_cursor_tracker_top.sv
// PS/2 mouse cursor tracker: assembles 3-byte packets into a clamped cursor position.
// A result is registered when the third byte of a packet is accepted.
// Throughput: one byte per cycle unless the skid register is full; one add and clamp.
// An output register plus one skid register keep input flowing while a result waits.
// Reset (synchronous, active low): screen 640x480, position (100,100), header hunt.
// Depends on pmct_pkg, pmct_in_if, pmct_out_if.
module ps2_mouse_cursor_tracker_top #(
    parameter int MAX_SCREEN = pmct_pkg::MAX_SCREEN_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pmct_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [pmct_pkg::CFG_W-1:0]     i_cfg_wdata,
    pmct_in_if.sink                        i_rx,
    pmct_out_if.source                     o_cur
);

    // Position width: enough for MAX_SCREEN-1 and for the start position
    localparam int POS_MIN_W = $clog2(pmct_pkg::START_POS + 1);
    localparam int POS_W = ($clog2(MAX_SCREEN) > POS_MIN_W) ? $clog2(MAX_SCREEN) : POS_MIN_W;
    // Unsigned compare width for limits, signed width for the sum
    localparam int CW = (POS_W + 1 > pmct_pkg::CFG_W) ? POS_W + 1 : pmct_pkg::CFG_W;
    localparam int SW = CW + 2;
    localparam logic [CW-1:0] MAX_V = CW'(MAX_SCREEN);

    typedef enum logic [1:0] {
        PH_HEAD,
        PH_XDELTA,
        PH_YDELTA
    } t_phase;

    logic [pmct_pkg::CFG_W-1:0] r_width, r_height;
    t_phase                     r_phase;
    logic                       r_left, r_right;
    logic [pmct_pkg::BYTE_W-1:0] r_dx;
    logic [POS_W-1:0]           r_pos_x, r_pos_y;
    pmct_pkg::t_result          r_out, r_skid;
    logic                       r_out_valid, r_skid_valid;

    logic              accept;
    logic              is_third;
    logic [POS_W-1:0]  n_pos_x, n_pos_y;
    pmct_pkg::t_result n_res;

    function automatic logic [CW-1:0] limit_of(input logic [pmct_pkg::CFG_W-1:0] size);
        logic [CW-1:0] s;
        s = CW'(size);
        if (s == '0) begin
            s = CW'(1);
        end else if (s > MAX_V) begin
            s = MAX_V;
        end
        return s;
    endfunction

    function automatic logic [POS_W-1:0] clamp_pos(input logic signed [SW-1:0] v,
                                                   input logic [CW-1:0] lim);
        logic [POS_W-1:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v[CW-1:0] >= lim) begin
            r = POS_W'(lim - CW'(1));
        end else begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

    assign i_rx.ready = !r_skid_valid;
    assign accept     = i_rx.valid && !r_skid_valid;

    always_comb begin
        logic signed [SW-1:0] sum_x, sum_y;
        case (r_phase)
            PH_HEAD:   is_third = 1'b0;
            PH_XDELTA: is_third = 1'b0;
            default:   is_third = 1'b1;
        endcase
        sum_x = $signed({2'b00, CW'(r_pos_x)}) + SW'($signed(r_dx));
        sum_y = $signed({2'b00, CW'(r_pos_y)}) - SW'($signed(i_rx.rx_byte));
        n_pos_x = clamp_pos(sum_x, limit_of(r_width));
        n_pos_y = clamp_pos(sum_y, limit_of(r_height));
        n_res.cursor_x   = pmct_pkg::COORD_W'(n_pos_x);
        n_res.cursor_y   = pmct_pkg::COORD_W'(n_pos_y);
        n_res.left_down  = r_left;
        n_res.right_down = r_right;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width      <= pmct_pkg::SCREEN_WIDTH_RST;
            r_height     <= pmct_pkg::SCREEN_HEIGHT_RST;
            r_phase      <= PH_HEAD;
            r_left       <= 1'b0;
            r_right      <= 1'b0;
            r_dx         <= '0;
            r_pos_x      <= POS_W'(pmct_pkg::START_POS);
            r_pos_y      <= POS_W'(pmct_pkg::START_POS);
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == pmct_pkg::REG_SCREEN_WIDTH) begin
                    r_width <= i_cfg_wdata;
                end else if (i_cfg_idx == pmct_pkg::REG_SCREEN_HEIGHT) begin
                    r_height <= i_cfg_wdata;
                end
            end

            if (accept) begin
                case (r_phase)
                    PH_HEAD: begin
                        // hunt for a header: sync bit must be set
                        if (i_rx.rx_byte[pmct_pkg::SYNC_BIT]) begin
                            r_left  <= i_rx.rx_byte[pmct_pkg::LEFT_BIT];
                            r_right <= i_rx.rx_byte[pmct_pkg::RIGHT_BIT];
                            r_phase <= PH_XDELTA;
                        end
                    end
                    PH_XDELTA: begin
                        r_dx    <= i_rx.rx_byte;
                        r_phase <= PH_YDELTA;
                    end
                    default: begin
                        r_pos_x <= n_pos_x;
                        r_pos_y <= n_pos_y;
                        r_phase <= PH_HEAD;
                    end
                endcase
            end

            if (!r_out_valid || o_cur.ready) begin
                if (r_skid_valid) begin
                    r_out        <= r_skid;
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else if (accept && is_third) begin
                    r_out       <= n_res;
                    r_out_valid <= 1'b1;
                end else begin
                    r_out_valid <= 1'b0;
                end
            end else if (accept && is_third) begin
                // output stalled: park the result in the skid register
                r_skid       <= n_res;
                r_skid_valid <= 1'b1;
            end
        end
    end

    assign o_cur.valid      = r_out_valid;
    assign o_cur.cursor_x   = r_out.cursor_x;
    assign o_cur.cursor_y   = r_out.cursor_y;
    assign o_cur.left_down  = r_out.left_down;
    assign o_cur.right_down = r_out.right_down;

endmodule

// File: bench/tb.sv
// Self-checking bench for ps2_mouse_cursor_tracker_top: mouse byte streams in,
// cursor reports checked against an in-bench packet tracker.
// Depends on pmct_pkg, pmct_in_if, pmct_out_if and the tracker RTL.
module tb;
    import pmct_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int MAX_ERR_LINES = 50;

    // register indexes with no register behind them; writes must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef enum logic [1:0] {PH_HUNT, PH_DX, PH_DY} t_pkt_phase;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0]     i_cfg_wdata = '0;

    pmct_in_if  rx_if();
    pmct_out_if cur_if();

    ps2_mouse_cursor_tracker_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_rx        (rx_if),
        .o_cur       (cur_if)
    );

    // tracker state, mirrors the block
    t_pkt_phase   trk_phase  = PH_HUNT;
    logic [7:0]   trk_header = '0;
    logic [7:0]   trk_dx     = '0;
    int           trk_x      = START_POS;
    int           trk_y      = START_POS;
    logic [CFG_W-1:0] scr_w  = SCREEN_WIDTH_RST;
    logic [CFG_W-1:0] scr_h  = SCREEN_HEIGHT_RST;

    logic [7:0] mouse_bytes_q[$];
    t_result    cursor_q[$];

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  err_count = 0;
    int  idle_cycles = 0;
    bit  rx_taken = 1'b0;

    initial forever #10 i_clk = ~i_clk;

    task automatic log_error(input string msg);
        err_count++;
        if (err_count <= MAX_ERR_LINES)
            $display("ERROR @%0t: %s", $time, msg);
    endtask

    function automatic int clamp_to_screen(input int v, input logic [CFG_W-1:0] size);
        int lim;
        lim = int'(size);
        if (lim < 1)
            lim = 1;
        if (lim > MAX_SCREEN_DEF)
            lim = MAX_SCREEN_DEF;
        if (v < 0)
            v = 0;
        if (v >= lim)
            v = lim - 1;
        return v;
    endfunction

    // Advances the packet tracker by one byte; returns 1 when a packet completes.
    function automatic bit track_cursor(input logic [7:0] b, output t_result rpt);
        rpt = '0;
        case (trk_phase)
            PH_HUNT: begin
                if (b[SYNC_BIT]) begin
                    trk_header = b;
                    trk_phase  = PH_DX;
                end
                return 1'b0;
            end
            PH_DX: begin
                trk_dx    = b;
                trk_phase = PH_DY;
                return 1'b0;
            end
            default: begin
                trk_phase = PH_HUNT;
                trk_x = clamp_to_screen(trk_x + int'($signed(trk_dx)), scr_w);
                trk_y = clamp_to_screen(trk_y - int'($signed(b)), scr_h);
                rpt.cursor_x   = COORD_W'(trk_x);
                rpt.cursor_y   = COORD_W'(trk_y);
                rpt.left_down  = trk_header[LEFT_BIT];
                rpt.right_down = trk_header[RIGHT_BIT];
                return 1'b1;
            end
        endcase
    endfunction

    // Byte driver: holds a request until taken, idles only between requests.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rx_if.valid <= 1'b0;
        end else if (!rx_if.valid || rx_taken) begin
            if (mouse_bytes_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                rx_if.valid   <= 1'b1;
                rx_if.rx_byte <= mouse_bytes_q.pop_front();
            end else begin
                rx_if.valid <= 1'b0;
            end
        end
        cur_if.ready <= i_rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Monitor: results are checked before the byte of the same edge is tracked.
    always @(posedge i_clk) begin
        t_result want;
        t_result got_rpt;
        bit      done;
        rx_taken = i_rst_n && rx_if.valid && rx_if.ready;
        if (!i_rst_n || i_cfg_we)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (i_rst_n && cur_if.valid && cur_if.ready) begin
            idle_cycles = 0;
            if (cursor_q.size() == 0) begin
                log_error($sformatf("unexpected cursor report x=%0d y=%0d",
                                    cur_if.cursor_x, cur_if.cursor_y));
            end else begin
                want = cursor_q.pop_front();
                if (cur_if.cursor_x !== want.cursor_x)
                    log_error($sformatf("cursor_x got %0d want %0d",
                                        cur_if.cursor_x, want.cursor_x));
                if (cur_if.cursor_y !== want.cursor_y)
                    log_error($sformatf("cursor_y got %0d want %0d",
                                        cur_if.cursor_y, want.cursor_y));
                if (cur_if.left_down !== want.left_down)
                    log_error($sformatf("left_down got %b want %b",
                                        cur_if.left_down, want.left_down));
                if (cur_if.right_down !== want.right_down)
                    log_error($sformatf("right_down got %b want %b",
                                        cur_if.right_down, want.right_down));
            end
        end
        if (rx_taken) begin
            idle_cycles = 0;
            done = track_cursor(rx_if.rx_byte, got_rpt);
            if (done)
                cursor_q.push_back(got_rpt);
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic queue_packet(input logic [7:0] hdr, input logic [7:0] dx,
                                input logic [7:0] dy);
        mouse_bytes_q.push_back(hdr);
        mouse_bytes_q.push_back(dx);
        mouse_bytes_q.push_back(dy);
    endtask

    function automatic logic [7:0] rand_delta();
        case ($urandom_range(0, 11))
            0: return 8'h7F;
            1: return 8'h80;
            2: return 8'h00;
            3: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // Mostly well-formed packets, some stray bytes and truncated packets.
    task automatic queue_motion(input int n_bytes);
        int         sent;
        int         pick;
        logic [7:0] hdr;
        logic [7:0] junk;
        sent = 0;
        while (sent < n_bytes) begin
            pick = $urandom_range(0, 99);
            hdr  = 8'($urandom);
            hdr[SYNC_BIT] = 1'b1;
            if (pick < 8) begin
                junk = 8'($urandom);
                junk[SYNC_BIT] = 1'b0;
                mouse_bytes_q.push_back(junk);
                sent += 1;
            end else if (pick < 13) begin
                mouse_bytes_q.push_back(hdr);
                mouse_bytes_q.push_back(rand_delta());
                sent += 2;
            end else begin
                queue_packet(hdr, rand_delta(), rand_delta());
                sent += 3;
            end
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (mouse_bytes_q.size() != 0 || rx_if.valid || cursor_q.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        case (idx)
            REG_SCREEN_WIDTH:  scr_w = data;
            REG_SCREEN_HEIGHT: scr_h = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_screen(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        // a partial packet may still sit in the block; let it settle before the writes
        repeat (3) @(negedge i_clk);
        write_reg(REG_SCREEN_WIDTH, w);
        write_reg(REG_SCREEN_HEIGHT, h);
    endtask

    initial begin
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = '0;
        cur_if.ready  = 1'b0;
        send_idle_pct = 34;
        recv_idle_pct = 47;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: dropped bytes, delta extremes, buttons, ignored sign bits
        mouse_bytes_q.push_back(8'h00);
        mouse_bytes_q.push_back(8'hF7);
        queue_packet(8'h08, 8'h7F, 8'h80);
        queue_packet(8'hFF, 8'h80, 8'h7F);
        queue_packet(8'h09, 8'h80, 8'h7F);
        queue_packet(8'h0A, 8'h00, 8'hFF);
        queue_packet(8'hF8, 8'h01, 8'h00);
        wait_drained();

        for (int seg = 0; seg < 7; seg++) begin
            if (seg == 3) begin
                send_idle_pct = 47;
                recv_idle_pct = 34;
            end else if (seg == 5) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (seg)
                1: set_screen(13'h1FFF, 13'd4097);
                2: set_screen(13'd50, 13'd30);  // shrink below the stored position
                3: begin
                    set_screen(13'd0, 13'd1);
                    write_reg(REG_SPARE_2, 13'h1FFF);
                    write_reg(REG_SPARE_3, 13'd5);
                end
                4: set_screen(13'd4096, 13'd4096);
                5: set_screen(CFG_W'($urandom_range(1, 300)), CFG_W'($urandom_range(1, 300)));
                6: set_screen(SCREEN_WIDTH_RST, SCREEN_HEIGHT_RST);
                default: ;
            endcase
            queue_motion(80);
            // sender holds off until every pending report is back
            wait_drained();
            queue_motion(80);
            wait_drained();
        end

        repeat (8) @(posedge i_clk);
        if (cursor_q.size() != 0)
            log_error($sformatf("%0d cursor reports never arrived", cursor_q.size()));
        if (err_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
